FILE: design/lpmt_pkg.sv
`default_nettype none
package lpmt_pkg;

    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;
    localparam int CMD_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // search word handed from cell to cell
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] mask;
    } t_srch;

    // table update broadcast to every cell
    typedef struct packed {
        logic              we;
        logic              clr;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic              enable;
    } t_wr;

endpackage
`default_nettype wire

FILE: design/lpmt_if.sv
`default_nettype none
// request channel
interface lpmt_req_if;
    import lpmt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] entry_slot;
    logic [ADDR_W-1:0] route_dest;
    logic [ADDR_W-1:0] route_mask;
    logic              route_enable;
    logic [ADDR_W-1:0] query_addr;

    modport source (output valid, cmd, entry_slot, route_dest, route_mask, route_enable,
                    query_addr, input ready);
    modport sink   (input valid, cmd, entry_slot, route_dest, route_mask, route_enable,
                    query_addr, output ready);
endinterface

// response channel
interface lpmt_rsp_if;
    import lpmt_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] best_slot;
    logic [ADDR_W-1:0] best_mask;

    modport source (output valid, found, best_slot, best_mask, input ready);
    modport sink   (input valid, found, best_slot, best_mask, output ready);
endinterface
`default_nettype wire

FILE: design/lpmt_cell.sv
`default_nettype none
module lpmt_cell
    import lpmt_pkg::*;
#(
    parameter int SLOT_IDX = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_wr   i_wr,
    input  wire logic  i_vld,
    input  wire t_srch i_srch,
    output logic       o_vld,
    output t_srch      o_srch
);

    // only the slots reachable by the 4-bit slot field can be written
    localparam bit               WRITABLE = (SLOT_IDX < (1 << SLOT_W));
    localparam logic [SLOT_W-1:0] SLOT_LO = SLOT_W'(SLOT_IDX);

    logic              r_valid;
    logic [ADDR_W-1:0] r_dest;
    logic [ADDR_W-1:0] r_mask;
    logic              r_vld;
    t_srch             r_srch;
    t_srch             n_srch;
    logic              wr_hit;
    logic              match;
    logic              take;

    assign wr_hit = WRITABLE && i_wr.we && (i_wr.slot == SLOT_LO);

    // route entry: valid mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.clr) begin
            r_valid <= 1'b0;
        end else if (wr_hit) begin
            r_valid <= i_wr.enable;
        end
    end

    // route entry: dest and mask, only read while valid
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_dest <= i_wr.dest;
            r_mask <= i_wr.mask;
        end
    end

    // compare against this entry, keep the longer mask (earlier slot on a tie)
    assign match = r_valid && ((i_srch.addr & r_mask) == (r_dest & r_mask));
    assign take  = match && (!i_srch.hit || (r_mask > i_srch.mask));

    always_comb begin
        n_srch = i_srch;
        if (take) begin
            n_srch.hit  = 1'b1;
            n_srch.slot = SLOT_LO;
            n_srch.mask = r_mask;
        end
    end

    // hand the search word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srch <= n_srch;
    end

    assign o_vld  = r_vld;
    assign o_srch = r_srch;

endmodule
`default_nettype wire

FILE: design/longest_prefix_match_table_unit.sv
`default_nettype none
// IPv4 longest-prefix-match route table. Every request word gives exactly one
// response word. Write and clear update the table (writes to a slot at or
// above TABLE_ENTRIES are dropped) and answer with an all-zero response in the
// cycle after acceptance, as do unused command codes. A lookup walks a search
// word down a row of TABLE_ENTRIES cells, one cell per cycle, each holding one
// route; the result is caught in a buffer at the end of the row and then
// loaded into the output register, reporting the matching valid route with
// the greatest mask (lowest slot on a tie; a zero mask is a default route
// that matches everything). One request is in flight at a time: the next is
// taken once the previous response has been loaded into the output register
// and that register is free again. No clearing pass is needed after reset.
module longest_prefix_match_table_unit
    import lpmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpmt_req_if.sink   i_req,
    lpmt_rsp_if.source o_rsp
);

    logic              acc;
    logic              acc_lookup;
    logic              out_free;
    logic              hold_move;
    t_wr               wr;
    logic              chain_vld [TABLE_ENTRIES+1];
    t_srch             chain_srch [TABLE_ENTRIES+1];

    logic              r_busy;
    logic              r_hold_vld;
    t_srch             r_hold;
    logic              r_ovld;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [ADDR_W-1:0] r_mask;

    // handshake
    assign out_free   = !r_ovld || o_rsp.ready;
    assign i_req.ready = !r_busy && out_free;
    assign acc        = i_req.valid && i_req.ready;
    assign acc_lookup = acc && (i_req.cmd == CMD_LOOKUP);
    assign hold_move  = r_hold_vld && out_free;

    // table update broadcast
    always_comb begin
        wr.we     = acc && (i_req.cmd == CMD_WRITE);
        wr.clr    = acc && (i_req.cmd == CMD_CLEAR);
        wr.slot   = i_req.entry_slot;
        wr.dest   = i_req.route_dest;
        wr.mask   = i_req.route_mask;
        wr.enable = i_req.route_enable;
    end

    // search word enters the first cell
    always_comb begin
        chain_vld[0]       = acc_lookup;
        chain_srch[0].addr = i_req.query_addr;
        chain_srch[0].hit  = 1'b0;
        chain_srch[0].slot = '0;
        chain_srch[0].mask = '0;
    end

    // row of route cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        lpmt_cell #(
            .SLOT_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_vld   (chain_vld[g]),
            .i_srch  (chain_srch[g]),
            .o_vld   (chain_vld[g+1]),
            .o_srch  (chain_srch[g+1])
        );
    end

    // control: lookup in flight, catch buffer at the end of the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            if (acc_lookup) begin
                r_busy <= 1'b1;
            end else if (hold_move) begin
                r_busy <= 1'b0;
            end
            if (chain_vld[TABLE_ENTRIES]) begin
                r_hold_vld <= 1'b1;
            end else if (hold_move) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_vld[TABLE_ENTRIES]) begin
            r_hold <= chain_srch[TABLE_ENTRIES];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if ((acc && !acc_lookup) || hold_move) begin
            r_ovld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !acc_lookup) begin
            r_found <= 1'b0;
            r_slot  <= '0;
            r_mask  <= '0;
        end else if (hold_move) begin
            r_found <= r_hold.hit;
            r_slot  <= r_hold.hit ? r_hold.slot : '0;
            r_mask  <= r_hold.hit ? r_hold.mask : '0;
        end
    end

    assign o_rsp.valid     = r_ovld;
    assign o_rsp.found     = r_found;
    assign o_rsp.best_slot = r_slot;
    assign o_rsp.best_mask = r_mask;

`ifndef SYNTHESIS
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.best_slot == '0 && o_rsp.best_mask == '0))
        else $error("miss response carries nonzero slot or mask");
    a_tail_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_vld[TABLE_ENTRIES] |-> (r_busy && !r_hold_vld))
        else $error("search word left the row with no lookup pending");
    a_lookup_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_lookup |=> r_busy)
        else $error("accepted lookup did not mark the unit busy");
    a_hold_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> (r_busy && !i_req.ready))
        else $error("held lookup result without busy");
`endif

endmodule
`default_nettype wire
